/* rtl/mbar_pkg.sv */
// Shared constants, status codes and character class type for the Modbus ASCII receiver.
package mbar_pkg;

  // Frame store limits
  localparam int unsigned MAX_FRAME_CHARS = 512;
  localparam int unsigned CHAR_COUNT_W    = 10;

  // Frame layout constants
  localparam int unsigned STD_FRAME_LEN   = 17;
  localparam int unsigned MIN_STATUS_LEN  = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_GOOD       = 2'd1,
    ST_ERROR      = 2'd2,
    ST_OVERRUN    = 2'd3
  } status_t;

  // Frame kinds held in the configuration register
  localparam logic KIND_REQUEST  = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  // Classified, case-folded character
  typedef struct packed {
    logic       keep;
    logic [7:0] ch;
    logic [3:0] nibble;
  } char_class_t;

endpackage

/* rtl/mbar_in_if.sv */
// Character request channel: one received ASCII character and a restart flag.
interface mbar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       restart;

  modport source (output valid, output char_in, output restart, input ready);
  modport sink (input valid, input char_in, input restart, output ready);
endinterface

/* rtl/mbar_out_if.sv */
// Status request channel: frame status and decoded header fields.
interface mbar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  unit_address;
  logic [7:0]  function_code;
  logic [15:0] register_address;
  logic [15:0] value_count;
  logic [9:0]  char_count;

  modport source (output valid, output status, output unit_address, output function_code,
                  output register_address, output value_count, output char_count,
                  input ready);
  modport sink (input valid, input status, input unit_address, input function_code,
                input register_address, input value_count, input char_count,
                output ready);
endinterface

/* rtl/mbar_char_class.sv */
// Character classifier: folds lowercase hex, flags frame characters, decodes the nibble.
module mbar_char_class
  import mbar_pkg::*;
(
  input  logic [7:0]  raw_char,
  output char_class_t cls
);

  logic is_digit;
  logic is_upper_hex;
  logic is_lower_hex;
  logic is_mark;

  assign is_digit     = (raw_char >= 8'h30) && (raw_char <= 8'h39);
  assign is_upper_hex = (raw_char >= 8'h41) && (raw_char <= 8'h46);
  assign is_lower_hex = (raw_char >= 8'h61) && (raw_char <= 8'h66);
  assign is_mark      = (raw_char == 8'h3A) || (raw_char == 8'h0D) || (raw_char == 8'h0A);

  // Fold case, then map to a nibble; colon, CR and LF decode as zero
  always_comb begin
    cls.keep   = is_digit || is_upper_hex || is_lower_hex || is_mark;
    cls.ch     = is_lower_hex ? (raw_char - 8'd32) : raw_char;
    cls.nibble = 4'd0;
    if (is_digit) begin
      cls.nibble = raw_char[3:0];
    end else if (is_upper_hex || is_lower_hex) begin
      cls.nibble = raw_char[3:0] + 4'd9;
    end
  end

endmodule

/* rtl/modbus_ascii_frame_receiver_core.sv */
// Top level of the Modbus ASCII frame receiver with running LRC check.
//
// Usage:
//   chars   - character requests (char_in, restart). Characters other than
//             hex digits, ':', CR and LF are dropped and give no status.
//             restart clears the frame store before the character is taken,
//             even when the character itself is dropped.
//   results - one status request per kept character: incomplete, complete
//             with good LRC, error, or overrun, with the decoded unit,
//             function, register, quantity fields and the characters held.
//   APB     - register 0 (byte address 0) bit 0 selects request (0) or
//             response (1) checking; write it only while the block is idle.
// A character accepted by chars sits in the input register, and the frame
// update loads its status into the result register when that register is free.
// Throughput is one character per cycle while results does not stall; the
// frame update between those two registers is combinational. When results
// stalls, the result register holds and the input register takes one more
// character before chars.ready drops.
// Reset clears the frame store, the frame kind and both registers' valid bits.
module modbus_ascii_frame_receiver_core
  import mbar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mbar_in_if.sink     chars,
  mbar_out_if.source  results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic       unknown;
    logic       bad;
    logic [9:0] len;
  } len_info_t;

  // Expected frame length from the fields received so far
  function automatic len_info_t expected_length(input logic [9:0] fl, input logic [7:0] func,
                                                input logic [7:0] bc, input logic kind);
    len_info_t r;
    r.unknown = 1'b0;
    r.bad     = 1'b0;
    r.len     = 10'(STD_FRAME_LEN);
    if (fl < 10'(MIN_STATUS_LEN)) begin
      r.unknown = 1'b1;
    end else if (kind == KIND_REQUEST) begin
      if (func == 8'd15 || func == 8'd16) begin
        if (fl < 10'd15) r.unknown = 1'b1;
        r.len = 10'd19 + {1'b0, bc, 1'b0};
      end
    end else begin
      if (func >= 8'd1 && func <= 8'd4) begin
        if (fl < 10'd7) r.unknown = 1'b1;
        r.len = 10'd11 + {1'b0, bc, 1'b0};
      end else if (!(func == 8'd5 || func == 8'd6 || func == 8'd15 || func == 8'd16)) begin
        r.bad = 1'b1;
      end
    end
    return r;
  endfunction

  // Configuration
  logic frame_kind;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_restart;
  logic       s1_go;
  logic       out_free;

  // Frame store
  logic [9:0]  frame_length, frame_length_next;
  logic [3:0]  pending_nibble, pending_nibble_next;
  logic [7:0]  byte_sum, byte_sum_next;
  logic [7:0]  held_unit, held_unit_next;
  logic [7:0]  held_function, held_function_next;
  logic [15:0] held_register, held_register_next;
  logic [15:0] held_count, held_count_next;
  logic [7:0]  held_byte_count, held_byte_count_next;
  logic [15:0] last_two_chars, last_two_chars_next;

  // Update path
  char_class_t cls;
  logic [9:0]  base_len;
  logic        overrun;
  logic [7:0]  byte_val;
  logic        byte_done;
  len_info_t   exp;
  status_t     status_next;

  mbar_char_class u_class (
    .raw_char (s1_char),
    .cls      (cls)
  );

  // APB register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, frame_kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind <= KIND_REQUEST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      frame_kind <= pwdata[0];
    end
  end

  // Handshake: dropped characters retire without a result slot
  assign out_free    = !results.valid || results.ready;
  assign s1_go       = s1_valid && (!cls.keep || out_free);
  assign chars.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready) begin
      s1_char    <= chars.char_in;
      s1_restart <= chars.restart;
    end
  end

  // Frame update for the character in the input register
  always_comb begin
    base_len             = s1_restart ? 10'd0 : frame_length;
    pending_nibble_next  = s1_restart ? 4'd0  : pending_nibble;
    byte_sum_next        = s1_restart ? 8'd0  : byte_sum;
    held_unit_next       = s1_restart ? 8'd0  : held_unit;
    held_function_next   = s1_restart ? 8'd0  : held_function;
    held_register_next   = s1_restart ? 16'd0 : held_register;
    held_count_next      = s1_restart ? 16'd0 : held_count;
    held_byte_count_next = s1_restart ? 8'd0  : held_byte_count;
    last_two_chars_next  = s1_restart ? 16'd0 : last_two_chars;
    frame_length_next    = base_len;
    overrun              = base_len >= 10'(MAX_FRAME_CHARS);
    byte_val             = {pending_nibble_next, cls.nibble};
    byte_done            = 1'b0;

    if (cls.keep && !overrun) begin
      frame_length_next   = base_len + 10'd1;
      last_two_chars_next = {last_two_chars_next[7:0], cls.ch};
      if (base_len != 10'd0) begin
        if (base_len[0]) begin
          pending_nibble_next = cls.nibble;
        end else begin
          byte_done = 1'b1;
          unique case (base_len)
            10'd2:   held_unit_next = byte_val;
            10'd4:   held_function_next = byte_val;
            10'd6:   held_register_next = {byte_val, held_register_next[7:0]};
            10'd8:   held_register_next = {held_register_next[15:8], byte_val};
            10'd10:  held_count_next = {byte_val, held_count_next[7:0]};
            10'd12:  held_count_next = {held_count_next[15:8], byte_val};
            default: ;
          endcase
          if ((frame_kind == KIND_REQUEST && base_len == 10'd14) ||
              (frame_kind == KIND_RESPONSE && base_len == 10'd6)) begin
            held_byte_count_next = byte_val;
          end
        end
      end
    end

    exp = expected_length(frame_length_next, held_function_next, held_byte_count_next,
                          frame_kind);

    // Sum only the bytes up to and including the LRC pair
    if (byte_done && (exp.unknown || exp.bad ||
                      ({1'b0, base_len} + 11'd3 <= {1'b0, exp.len}))) begin
      byte_sum_next = byte_sum_next + byte_val;
    end

    priority if (overrun) begin
      status_next = ST_OVERRUN;
    end else if (frame_length_next < 10'(MIN_STATUS_LEN) || exp.unknown) begin
      status_next = ST_INCOMPLETE;
    end else if (exp.bad || frame_length_next > exp.len) begin
      status_next = ST_ERROR;
    end else if (frame_length_next < exp.len) begin
      status_next = ST_INCOMPLETE;
    end else if (frame_kind == KIND_RESPONSE && last_two_chars_next != 16'h0D0A) begin
      status_next = ST_ERROR;
    end else if (byte_sum_next == 8'd0) begin
      status_next = ST_GOOD;
    end else begin
      status_next = ST_ERROR;
    end
  end

  // Advance the frame store when the input register retires
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length    <= 10'd0;
      pending_nibble  <= 4'd0;
      byte_sum        <= 8'd0;
      held_unit       <= 8'd0;
      held_function   <= 8'd0;
      held_register   <= 16'd0;
      held_count      <= 16'd0;
      held_byte_count <= 8'd0;
      last_two_chars  <= 16'd0;
    end else if (s1_go) begin
      frame_length    <= frame_length_next;
      pending_nibble  <= pending_nibble_next;
      byte_sum        <= byte_sum_next;
      held_unit       <= held_unit_next;
      held_function   <= held_function_next;
      held_register   <= held_register_next;
      held_count      <= held_count_next;
      held_byte_count <= held_byte_count_next;
      last_two_chars  <= last_two_chars_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_go && cls.keep) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && cls.keep) begin
      results.status           <= status_next;
      results.unit_address     <= held_unit_next;
      results.function_code    <= held_function_next;
      results.register_address <= held_register_next;
      results.value_count      <= held_count_next;
      results.char_count       <= frame_length_next;
    end
  end

`ifndef SYNTH
  // Frame store never grows past its limit
  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    frame_length <= 10'(MAX_FRAME_CHARS))
    else $error("frame length beyond limit");

  // Overrun is only reported with a full frame store
  a_overrun_full: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_OVERRUN |->
      results.char_count == 10'(MAX_FRAME_CHARS))
    else $error("overrun reported with room left");

  // A good frame has at least the shortest response length and a zero sum
  a_good_frame: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.status == ST_GOOD |->
      results.char_count >= 10'd11 && byte_sum == 8'd0)
    else $error("good status on a short frame or nonzero sum");

  // Input stalls only behind a held character
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> s1_valid && cls.keep && !out_free)
    else $error("input stalled without a pending character");
`endif

endmodule

/* bench/tb_modbus_ascii_frame_receiver_core.sv */
// Self-checking bench for the Modbus ASCII frame receiver: frame stimulus, status predictor.
`timescale 1ns / 100ps

module tb_modbus_ascii_frame_receiver_core;
  import mbar_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic [2:0] REG_FRAME_KIND_ADDR = 3'd0;

  // Characters of the frame syntax
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [15:0] CRLF    = 16'h0D0A;

  // Function codes that set the frame length
  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_REG = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
  localparam logic [7:0] FC_WRITE_REG      = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

  // Expected length markers
  localparam int unsigned LEN_PENDING = 0;
  localparam int unsigned LEN_INVALID = 32'hFFFF;

  // Ways a generated frame is damaged
  localparam int FLAW_NONE   = 0;
  localparam int FLAW_LRC    = 1;
  localparam int FLAW_COLON  = 2;
  localparam int FLAW_ENDING = 3;
  localparam int FLAW_SHORT  = 4;

  typedef struct {
    logic [7:0] ch;
    logic       restart;
  } char_req_t;

  typedef struct {
    status_t     status;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [15:0] register;
    logic [15:0] quantity;
    logic [9:0]  chars;
  } frame_status_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbar_in_if  chars_if ();
  mbar_out_if res_if ();

  modbus_ascii_frame_receiver_core u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if.sink),
    .results (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  char_req_t     char_q[$];
  frame_status_t status_q[$];
  char_req_t     drive_item;
  logic          char_taken;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  logic          hold_go;
  int unsigned   hold_left;
  int unsigned   cycle_count;
  int unsigned   mismatches;

  // Predictor copy of the frame store
  logic        pred_kind;
  int unsigned fr_len;
  logic [3:0]  hi_nibble;
  logic [7:0]  lrc_sum;
  logic [7:0]  unit_q;
  logic [7:0]  func_q;
  logic [15:0] register_q;
  logic [15:0] quantity_q;
  logic [7:0]  byte_count_q;
  logic [15:0] tail_chars;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void clear_frame();
    fr_len       = 0;
    hi_nibble    = '0;
    lrc_sum      = '0;
    unit_q       = '0;
    func_q       = '0;
    register_q   = '0;
    quantity_q   = '0;
    byte_count_q = '0;
    tail_chars   = '0;
  endfunction

  function automatic bit is_frame_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f") ||
           c == CH_COLON || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  // Length the frame must reach, from the header seen so far
  function automatic int unsigned frame_target();
    if (fr_len < MIN_STATUS_LEN) return LEN_PENDING;
    if (pred_kind == KIND_REQUEST) begin
      if (func_q == FC_WRITE_COILS || func_q == FC_WRITE_REGS) begin
        if (fr_len < 15) return LEN_PENDING;
        return 19 + 2 * byte_count_q;
      end
      return STD_FRAME_LEN;
    end
    if (func_q >= FC_READ_COILS && func_q <= FC_READ_INPUT_REG) begin
      if (fr_len < 7) return LEN_PENDING;
      return 11 + 2 * byte_count_q;
    end
    if (func_q == FC_WRITE_COIL || func_q == FC_WRITE_REG ||
        func_q == FC_WRITE_COILS || func_q == FC_WRITE_REGS) return STD_FRAME_LEN;
    return LEN_INVALID;
  endfunction

  // Apply one character; returns 1 when it produces a status
  function automatic bit predict_status(input logic [7:0] raw, input logic rs,
                                        output frame_status_t r);
    logic [7:0]  c;
    logic [7:0]  b;
    int unsigned pos;
    int unsigned tgt;
    status_t     st;
    if (rs) clear_frame();
    c = raw;
    if (c >= "a" && c <= "f") c = c - 8'd32;
    else if (!is_frame_char(c)) return 1'b0;
    if (fr_len >= MAX_FRAME_CHARS) begin
      st = ST_OVERRUN;
    end else begin
      pos = fr_len;
      fr_len++;
      tail_chars = {tail_chars[7:0], c};
      if (pos >= 1) begin
        if (pos % 2 == 1) begin
          hi_nibble = hex_value(c);
        end else begin
          b = {hi_nibble, hex_value(c)};
          case (pos)
            2: unit_q = b;
            4: func_q = b;
            6: register_q[15:8] = b;
            8: register_q[7:0] = b;
            10: quantity_q[15:8] = b;
            12: quantity_q[7:0] = b;
            default: ;
          endcase
          if ((pred_kind == KIND_REQUEST && pos == 14) ||
              (pred_kind == KIND_RESPONSE && pos == 6)) byte_count_q = b;
          tgt = frame_target();
          if (tgt == LEN_PENDING || tgt == LEN_INVALID || pos + 3 <= tgt)
            lrc_sum = lrc_sum + b;
        end
      end
      tgt = frame_target();
      if (fr_len < MIN_STATUS_LEN || tgt == LEN_PENDING) st = ST_INCOMPLETE;
      else if (tgt == LEN_INVALID || fr_len > tgt) st = ST_ERROR;
      else if (fr_len < tgt) st = ST_INCOMPLETE;
      else if (pred_kind == KIND_RESPONSE && tail_chars != CRLF) st = ST_ERROR;
      else st = (lrc_sum == 8'd0) ? ST_GOOD : ST_ERROR;
    end
    r.status   = st;
    r.unit     = unit_q;
    r.func     = func_q;
    r.register = register_q;
    r.quantity = quantity_q;
    r.chars    = 10'(fr_len);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    mismatches++;
    $display("%0t: %s mismatch: got 'h%0h, expected 'h%0h", $time, what, got, want_v);
  endtask

  // Drive character requests at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!chars_if.valid || char_taken) begin
      if (char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = char_q.pop_front();
        chars_if.valid   <= 1'b1;
        chars_if.char_in <= drive_item.ch;
        chars_if.restart <= drive_item.restart;
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
  end

  // Count down a long receiver hold-off
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
      hold_go   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drive status ready with random stalls
  always @(negedge clk) begin
    res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on each accepted character
  always @(posedge clk) begin : predict_accepted
    frame_status_t r;
    if (!rst && chars_if.valid && chars_if.ready) begin
      if (predict_status(chars_if.char_in, chars_if.restart, r)) status_q.push_back(r);
    end
    char_taken <= !rst && chars_if.valid && chars_if.ready;
  end

  // Compare each accepted status with the oldest prediction
  always @(posedge clk) begin : check_status
    frame_status_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected status", res_if.status, 0);
      end else begin
        want = status_q.pop_front();
        if (res_if.status != want.status)
          report_mismatch("status", res_if.status, want.status);
        if (res_if.unit_address != want.unit)
          report_mismatch("unit_address", res_if.unit_address, want.unit);
        if (res_if.function_code != want.func)
          report_mismatch("function_code", res_if.function_code, want.func);
        if (res_if.register_address != want.register)
          report_mismatch("register_address", res_if.register_address, want.register);
        if (res_if.value_count != want.quantity)
          report_mismatch("value_count", res_if.value_count, want.quantity);
        if (res_if.char_count != want.chars)
          report_mismatch("char_count", res_if.char_count, want.chars);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("modbus_ascii_frame_receiver_core regression: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (a == REG_FRAME_KIND_ADDR) pred_kind = d[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] a, output logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    d = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_kind(input logic k);
    logic [31:0] rd;
    apb_write(REG_FRAME_KIND_ADDR, {31'd0, k});
    apb_read(REG_FRAME_KIND_ADDR, rd);
    if (rd != {31'd0, k}) report_mismatch("frame_kind readback", rd, k);
  endtask

  // Hold until all characters are taken and every status has come back
  task automatic wait_idle();
    while (char_q.size() > 0 || chars_if.valid) @(posedge clk);
    while (status_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_char(input logic [7:0] c, input logic rs);
    char_req_t it;
    it.ch      = c;
    it.restart = rs;
    char_q.push_back(it);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_frame_char(c));
    return c;
  endfunction

  // Two hex digits, sometimes with an ignored character in between
  task automatic push_byte(input logic [7:0] b, input bit lower);
    push_char(hex_char(b[7:4], lower && $urandom_range(1)), 1'b0);
    if ($urandom_range(49) == 0) push_char(pick_noise(), 1'b0);
    push_char(hex_char(b[3:0], lower && $urandom_range(1)), 1'b0);
  endtask

  function automatic logic [7:0] pick_function();
    case ($urandom_range(5))
      0: return FC_WRITE_REGS;
      1: return FC_WRITE_COILS;
      2: return 8'($urandom_range(255));
      default: return 8'($urandom_range(FC_READ_COILS, FC_WRITE_REG));
    endcase
  endfunction

  // Emit one frame with random content; long_n >= 0 forces a data block of that size
  task automatic push_frame(input logic as_resp, input int long_n);
    logic [7:0] body[$];
    logic [7:0] fc;
    logic [7:0] sum;
    int         n;
    int         flaw;
    int         cut;
    bit         lower;
    lower = ($urandom_range(3) == 0);
    flaw  = ($urandom_range(9) == 0) ? $urandom_range(FLAW_LRC, FLAW_SHORT) : FLAW_NONE;
    n     = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(4);
    fc    = pick_function();
    if (long_n >= 0) begin
      flaw = FLAW_NONE;
      n    = long_n;
      fc   = as_resp ? FC_READ_HOLDING : FC_WRITE_REGS;
    end
    body.push_back(8'($urandom_range(255)));
    body.push_back(fc);
    if (!as_resp) begin
      repeat (4) body.push_back(8'($urandom_range(255)));
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom_range(255)));
      end
    end else if (fc >= FC_READ_COILS && fc <= FC_READ_INPUT_REG) begin
      body.push_back(8'(n));
      repeat (n) body.push_back(8'($urandom_range(255)));
    end else begin
      repeat (4) body.push_back(8'($urandom_range(255)));
    end
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    body.push_back(8'(-sum));
    if (flaw == FLAW_LRC) body[body.size() - 1] ^= 8'h01 << $urandom_range(7);
    cut = $urandom_range(body.size() - 1);

    // An ignored character may still carry the restart
    if ($urandom_range(15) == 0) push_char(pick_noise(), 1'b1);
    push_char(CH_COLON, $urandom_range(7) != 0);
    for (int i = 0; i < body.size(); i++) begin
      if (flaw == FLAW_SHORT && i == cut) break;
      if (flaw == FLAW_COLON && i == cut) begin
        push_char(hex_char(body[i][7:4], lower), 1'b0);
        push_char(CH_COLON, 1'b0);
      end else begin
        push_byte(body[i], lower);
      end
    end
    if (flaw != FLAW_SHORT) begin
      push_char(CH_CR, 1'b0);
      push_char(flaw == FLAW_ENDING ? CH_CR : CH_LF, 1'b0);
    end
  endtask

  task automatic run_frames(input logic k, input int target, input int unsigned s_pct,
                            input int unsigned r_pct);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    while (char_q.size() < target) push_frame(k, -1);
    wait_idle();
  endtask

  initial begin
    chars_if.valid   = 1'b0;
    chars_if.char_in = '0;
    chars_if.restart = 1'b0;
    res_if.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rst              = 1'b1;
    char_taken       = 1'b0;
    hold_go          = 1'b0;
    hold_left        = 0;
    cycle_count      = 0;
    mismatches       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    pred_kind        = KIND_REQUEST;
    clear_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_kind(KIND_REQUEST);

    // Ignored characters at the byte extremes, one carrying a restart
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b0);
    push_char("z", 1'b0);
    // Good standard request written with hex digits in random case
    push_char(CH_COLON, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h03, 1'b1);
    push_byte(8'hAB, 1'b1);
    push_byte(8'hCD, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h0F, 1'b1);
    push_byte(8'(-(8'hFF + 8'h03 + 8'hAB + 8'hCD + 8'h0F)), 1'b1);
    push_char(CH_CR, 1'b0);
    push_char(CH_LF, 1'b0);
    // Short frame with frame marks at digit places
    push_char(CH_COLON, 1'b1);
    push_char(CH_CR, 1'b0);
    push_char(CH_LF, 1'b0);
    wait_idle();

    run_frames(KIND_REQUEST, 350, 64, 0);

    // Leave a frame open across the kind change
    push_char(CH_COLON, 1'b1);
    push_byte(8'($urandom_range(255)), 1'b0);
    push_byte(8'($urandom_range(FC_READ_COILS, FC_READ_INPUT_REG)), 1'b0);
    wait_idle();
    set_kind(KIND_RESPONSE);
    repeat (3) push_byte(8'($urandom_range(8)), 1'b0);
    run_frames(KIND_RESPONSE, 350, 0, 64);

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (char_q.size() < 60) push_frame(KIND_RESPONSE, -1);
    @(posedge clk);
    hold_go = 1'b1;
    wait_idle();

    set_kind(KIND_REQUEST);
    push_frame(KIND_REQUEST, 255);
    run_frames(KIND_REQUEST, 550, 12, 12);

    set_kind(KIND_RESPONSE);
    push_frame(KIND_RESPONSE, 255);
    run_frames(KIND_RESPONSE, 550, 0, 0);

    if (mismatches == 0) begin
      $display("modbus_ascii_frame_receiver_core regression: pass");
    end else begin
      $display("modbus_ascii_frame_receiver_core regression: fail");
    end
    $finish;
  end

endmodule
